/* sv/png_cdf_pkg.sv */
// Shared types, codes and the CRC-32 byte update for the PNG chunk deframer.
`default_nettype none

package png_cdf_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam int unsigned ANC_BIT = 5;

	typedef enum logic [2:0] {
		PH_LEN  = 3'd0,
		PH_TYPE = 3'd1,
		PH_DATA = 3'd2,
		PH_CRC  = 3'd3,
		PH_HALT = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		EV_HDR  = 2'd0,
		EV_DATA = 2'd1,
		EV_GOOD = 2'd2,
		EV_BAD  = 2'd3
	} event_t;

	typedef struct packed {
		event_t      ev;
		logic [7:0]  data_byte;
		logic [31:0] chunk_type;
		logic [31:0] chunk_length;
	} result_t;

	// Handshake between the input stage and the parser.
	typedef struct packed {
		logic       adv;
		logic [7:0] in_byte;
	} step_t;

	// Reflected CRC-32 update over one byte, eight bit steps unrolled.
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? (CRC_POLY ^ {1'b0, r[31:1]}) : {1'b0, r[31:1]};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* sv/png_cdf_in_if.sv */
// Byte stream channel into the deframer.
`default_nettype none

interface png_cdf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

/* sv/png_cdf_out_if.sv */
// Event channel out of the deframer.
`default_nettype none

interface png_cdf_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_res;
	logic [7:0]  data_byte;
	logic [31:0] chunk_type;
	logic [31:0] chunk_length;

	modport source (output valid, output event_res, output data_byte,
		output chunk_type, output chunk_length, input ready);
	modport sink (input valid, input event_res, input data_byte,
		input chunk_type, input chunk_length, output ready);
endinterface

`default_nettype wire

/* sv/png_cdf_in_stage.sv */
// Input register stage: captures one stream word and hands it to the parser.
`default_nettype none

module png_cdf_in_stage
	import png_cdf_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire  [7:0]  in_byte,
	output logic        in_ready,
	input  wire         out_free,
	output step_t       step
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv;

	// Advance the held word when the result register can take its outcome.
	assign adv      = valid_s1 & out_free;
	assign in_ready = ~valid_s1 | out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	assign step.adv     = adv;
	assign step.in_byte = byte_s1;

endmodule

`default_nettype wire

/* sv/png_cdf_parser.sv */
// Chunk parser: field counting, CRC-32 accumulation and event generation.
`default_nettype none

module png_cdf_parser
	import png_cdf_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  step_t       step,
	output logic        res_valid,
	output result_t     res
);

	phase_t      phase_q, phase_d;
	logic [1:0]  field_cnt_q, field_cnt_d;
	logic [31:0] data_cnt_q, data_cnt_d;
	logic [31:0] length_q, length_d;
	logic [31:0] type_q, type_d;
	logic [31:0] crc_q, crc_d;
	logic [31:0] rx_crc_q, rx_crc_d;
	logic        anc_q, anc_d;

	logic        last;
	logic [31:0] crc_upd;
	logic [31:0] data_cnt_inc;

	assign last         = (field_cnt_q == 2'd3);
	assign crc_upd      = crc_byte(crc_q, step.in_byte);
	assign data_cnt_inc = data_cnt_q + 32'd1;

	// Next state
	always_comb begin
		phase_d     = phase_q;
		field_cnt_d = field_cnt_q;
		data_cnt_d  = data_cnt_q;
		length_d    = length_q;
		type_d      = type_q;
		crc_d       = crc_q;
		rx_crc_d    = rx_crc_q;
		anc_d       = anc_q;
		case (phase_q)
			PH_LEN: begin
				length_d    = {length_q[23:0], step.in_byte};
				field_cnt_d = field_cnt_q + 2'd1;
				if (last) begin
					phase_d = PH_TYPE;
					crc_d   = CRC_INIT;
				end
			end
			PH_TYPE: begin
				type_d      = {type_q[23:0], step.in_byte};
				crc_d       = crc_upd;
				field_cnt_d = field_cnt_q + 2'd1;
				if (last) begin
					anc_d      = type_q[16 + ANC_BIT];
					data_cnt_d = '0;
					phase_d    = (length_q == '0) ? PH_CRC : PH_DATA;
				end
			end
			PH_DATA: begin
				crc_d      = crc_upd;
				data_cnt_d = data_cnt_inc;
				if (data_cnt_inc == length_q) begin
					phase_d = PH_CRC;
				end
			end
			PH_CRC: begin
				rx_crc_d    = {rx_crc_q[23:0], step.in_byte};
				field_cnt_d = field_cnt_q + 2'd1;
				if (last) begin
					if (anc_q || (~crc_q == {rx_crc_q[23:0], step.in_byte})) begin
						crc_d   = CRC_INIT;
						phase_d = PH_LEN;
					end else begin
						phase_d = PH_HALT;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Result
	always_comb begin
		res_valid        = 1'b0;
		res.ev           = EV_HDR;
		res.data_byte    = '0;
		res.chunk_type   = type_q;
		res.chunk_length = length_q;
		case (phase_q)
			PH_TYPE: begin
				res.chunk_type = {type_q[23:0], step.in_byte};
				res_valid      = step.adv & last & ~type_q[16 + ANC_BIT];
			end
			PH_DATA: begin
				res.ev        = EV_DATA;
				res.data_byte = step.in_byte;
				res_valid     = step.adv & ~anc_q;
			end
			PH_CRC: begin
				res.ev    = (~crc_q == {rx_crc_q[23:0], step.in_byte}) ? EV_GOOD : EV_BAD;
				res_valid = step.adv & last & ~anc_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEN;
			field_cnt_q <= '0;
			data_cnt_q  <= '0;
			length_q    <= '0;
			type_q      <= '0;
			crc_q       <= CRC_INIT;
			rx_crc_q    <= '0;
			anc_q       <= 1'b0;
		end else if (step.adv) begin
			phase_q     <= phase_d;
			field_cnt_q <= field_cnt_d;
			data_cnt_q  <= data_cnt_d;
			length_q    <= length_d;
			type_q      <= type_d;
			crc_q       <= crc_d;
			rx_crc_q    <= rx_crc_d;
			anc_q       <= anc_d;
		end
	end

endmodule

`default_nettype wire

/* sv/png_cdf_out_reg.sv */
// Result register: holds one event word until the receiver takes it.
`default_nettype none

module png_cdf_out_reg
	import png_cdf_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         res_valid,
	input  result_t     res,
	input  wire         out_ready,
	output logic        out_valid,
	output result_t     out_word,
	output logic        out_free
);

	logic    valid_q;
	result_t word_q;

	assign out_free  = ~valid_q | out_ready;
	assign out_valid = valid_q;
	assign out_word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			word_q <= res;
		end
	end

endmodule

`default_nettype wire

/* sv/png_chunk_deframer_crc_check.sv */
// PNG chunk deframer with CRC-32 check: top level.
// Usage:
//   in_ch carries the chunk stream, one byte per word, starting at a chunk
//   boundary (length, type, data, CRC). out_ch carries events: a header word
//   for each critical chunk, one word per data byte, then CRC good or
//   mismatch. Ancillary chunks are consumed without any output word.
//   Every output word also carries the current chunk type and length.
// Path: an accepted byte is held in the input register; its event word is
//   loaded into the result register when the byte advances and is then
//   presented on out_ch.
// Throughput: one byte per cycle unless stalled; the CRC byte update, data
//   counter compare and field shifts all resolve in the single parse stage.
// Reset: arst_n clears both registers and returns the parser to the length
//   field with the CRC preset to all ones.
// Stall: while out_ch.ready is low and an event word is held, the input
//   register holds its byte and in_ch.ready drops once it is full.
// After a CRC mismatch the block keeps accepting bytes but emits nothing
//   until reset.
`default_nettype none

module png_chunk_deframer_crc_check
	import png_cdf_pkg::*;
(
	input  wire            clk,
	input  wire            arst_n,
	png_cdf_in_if.sink     in_ch,
	png_cdf_out_if.source  out_ch
);

	step_t   step;
	logic    out_free;
	logic    res_valid;
	result_t res;
	result_t out_word;

	png_cdf_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_byte  (in_ch.in_byte),
		.in_ready (in_ch.ready),
		.out_free (out_free),
		.step     (step)
	);

	png_cdf_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.res_valid (res_valid),
		.res       (res)
	);

	png_cdf_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.out_word  (out_word),
		.out_free  (out_free)
	);

	assign out_ch.event_res    = out_word.ev;
	assign out_ch.data_byte    = out_word.data_byte;
	assign out_ch.chunk_type   = out_word.chunk_type;
	assign out_ch.chunk_length = out_word.chunk_length;

endmodule

`default_nettype wire

/* tb/png_chunk_deframer_crc_check_tb.sv */
// Self-checking testbench for the PNG chunk deframer with its CRC-32 check.
`timescale 1ns / 1ps

module png_chunk_deframer_crc_check_tb;
	import png_cdf_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	// Tracks the chunk parser and holds the event words it should produce.
	class chunk_scoreboard;
		phase_t      cur_phase;
		logic [1:0]  field_cnt;
		logic [31:0] data_cnt;
		logic [31:0] len_word;
		logic [31:0] type_word;
		logic [31:0] crc_acc;
		logic [31:0] rx_crc;
		logic        ancillary;
		result_t     pending[$];
		int          errors;

		function new();
			cur_phase = PH_LEN;
			field_cnt = '0;
			data_cnt = '0;
			len_word = '0;
			type_word = '0;
			crc_acc = CRC_INIT;
			rx_crc = '0;
			ancillary = 1'b0;
			errors = 0;
		endfunction

		// Reflected CRC-32, one input bit per step, low bit first.
		static function logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
			logic [31:0] r;
			r = c;
			for (int i = 0; i < 8; i++) begin
				if (r[0] ^ b[i])
					r = (r >> 1) ^ CRC_POLY;
				else
					r = r >> 1;
			end
			return r;
		endfunction

		function void queue_word(input event_t ev, input logic [7:0] d);
			result_t w;
			w.ev = ev;
			w.data_byte = d;
			w.chunk_type = type_word;
			w.chunk_length = len_word;
			pending.push_back(w);
		endfunction

		function void note_byte(input logic [7:0] b);
			logic last;
			last = (field_cnt == 2'd3);
			case (cur_phase)
				PH_LEN: begin
					len_word = {len_word[23:0], b};
					field_cnt = field_cnt + 2'd1;
					if (last) begin
						cur_phase = PH_TYPE;
						crc_acc = CRC_INIT;
					end
				end
				PH_TYPE: begin
					type_word = {type_word[23:0], b};
					crc_acc = crc_update(crc_acc, b);
					field_cnt = field_cnt + 2'd1;
					if (last) begin
						ancillary = type_word[24 + ANC_BIT];
						data_cnt = '0;
						if (len_word == 32'd0)
							cur_phase = PH_CRC;
						else
							cur_phase = PH_DATA;
						if (!ancillary)
							queue_word(EV_HDR, 8'h00);
					end
				end
				PH_DATA: begin
					crc_acc = crc_update(crc_acc, b);
					data_cnt = data_cnt + 32'd1;
					if (data_cnt == len_word)
						cur_phase = PH_CRC;
					if (!ancillary)
						queue_word(EV_DATA, b);
				end
				PH_CRC: begin
					rx_crc = {rx_crc[23:0], b};
					field_cnt = field_cnt + 2'd1;
					if (last) begin
						if (ancillary) begin
							crc_acc = CRC_INIT;
							cur_phase = PH_LEN;
						end else if (~crc_acc == rx_crc) begin
							crc_acc = CRC_INIT;
							cur_phase = PH_LEN;
							queue_word(EV_GOOD, 8'h00);
						end else begin
							cur_phase = PH_HALT;
							queue_word(EV_BAD, 8'h00);
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void check_word(input result_t got);
			result_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected word: expected none, actual ev=%0d data=%02h type=%08h len=%08h",
					$time, got.ev, got.data_byte, got.chunk_type, got.chunk_length);
				return;
			end
			want = pending.pop_front();
			if (got.ev !== want.ev) begin
				errors++;
				$display("%0t: event expected %0d actual %0d", $time, want.ev, got.ev);
			end
			if (got.data_byte !== want.data_byte) begin
				errors++;
				$display("%0t: data_byte expected %02h actual %02h", $time,
					want.data_byte, got.data_byte);
			end
			if (got.chunk_type !== want.chunk_type) begin
				errors++;
				$display("%0t: chunk_type expected %08h actual %08h", $time,
					want.chunk_type, got.chunk_type);
			end
			if (got.chunk_length !== want.chunk_length) begin
				errors++;
				$display("%0t: chunk_length expected %08h actual %08h", $time,
					want.chunk_length, got.chunk_length);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic tx_steady = 1'b0;
	int   bytes_sent = 0;

	chunk_scoreboard sb = new();

	png_cdf_in_if  in_ch();
	png_cdf_out_if out_ch();

	png_chunk_deframer_crc_check DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	task automatic send_word32(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			send_byte(w[31 - 8*i -: 8]);
	endtask

	task automatic send_chunk(input logic [31:0] ctype, input byte_q_t payload,
			input logic corrupt);
		logic [31:0] crc;
		logic [31:0] mask;
		crc = CRC_INIT;
		for (int i = 0; i < 4; i++)
			crc = chunk_scoreboard::crc_update(crc, ctype[31 - 8*i -: 8]);
		foreach (payload[i])
			crc = chunk_scoreboard::crc_update(crc, payload[i]);
		crc = ~crc;
		if (corrupt) begin
			mask = $urandom();
			if (mask == 32'd0)
				mask = 32'd1;
			crc = crc ^ mask;
		end
		send_word32(payload.size());
		send_word32(ctype);
		foreach (payload[i])
			send_byte(payload[i]);
		send_word32(crc);
	endtask

	// Mostly short chunks; ancillary ones may carry a broken CRC since it is never checked.
	task automatic send_random_chunk();
		byte_q_t     payload;
		logic [31:0] ctype;
		logic        anc;
		logic        corrupt;
		int          len;
		int          pick;
		pick = $urandom_range(0, 19);
		if (pick < 3)
			len = 0;
		else if (pick < 17)
			len = $urandom_range(1, 16);
		else
			len = $urandom_range(17, 300);
		for (int i = 0; i < len; i++)
			payload.push_back(8'($urandom_range(0, 255)));
		ctype = $urandom();
		anc = ($urandom_range(0, 9) < 4);
		ctype[24 + ANC_BIT] = anc;
		corrupt = anc && ($urandom_range(0, 1) == 1);
		tx_steady = ($urandom_range(0, 3) == 0);
		send_chunk(ctype, payload, corrupt);
	endtask

	initial begin : stimulus
		byte_q_t     payload;
		logic [31:0] ctype;
		int          target;
		int          len;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.in_byte <= 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// critical chunk with both byte extremes, then an empty ancillary one with a bad CRC
		payload = '{8'h00, 8'hFF};
		send_chunk(32'h4944_4154, payload, 1'b0);
		payload = {};
		send_chunk(32'h7445_5874, payload, 1'b1);

		while (bytes_sent < 650)
			send_random_chunk();

		// one longer critical chunk at full rate so the data count runs past nine bits
		payload = {};
		for (int i = 0; i < 600; i++)
			payload.push_back(8'($urandom_range(0, 255)));
		ctype = $urandom();
		ctype[24 + ANC_BIT] = 1'b0;
		tx_steady = 1'b1;
		send_chunk(ctype, payload, 1'b0);

		target = bytes_sent + 650;
		while (bytes_sent < target)
			send_random_chunk();

		// a bad CRC on a critical chunk halts the block; trailing bytes must be dropped
		payload = {};
		len = $urandom_range(0, 8);
		for (int i = 0; i < len; i++)
			payload.push_back(8'($urandom_range(0, 255)));
		ctype = $urandom();
		ctype[24 + ANC_BIT] = 1'b0;
		tx_steady = 1'b0;
		send_chunk(ctype, payload, 1'b1);
		send_byte(8'h00);
		send_byte(8'hFF);
		for (int i = 0; i < 12; i++)
			send_byte(8'($urandom_range(0, 255)));
		in_ch.valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin : drain
		result_t got;
		int      hold;
		int      words;
		logic    rx_steady;
		words = 0;
		rx_steady = 1'b0;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (words % 40 == 0)
				rx_steady = ($urandom_range(0, 3) == 0);
			hold = rx_steady ? 0 : $urandom_range(0, 7);
			// long hold-off: the sender keeps offering, so the block must back up
			if (words == 400)
				hold = 300;
			if (hold > 0) begin
				out_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
			got.ev = event_t'(out_ch.event_res);
			got.data_byte = out_ch.data_byte;
			got.chunk_type = out_ch.chunk_type;
			got.chunk_length = out_ch.chunk_length;
			sb.check_word(got);
			words++;
		end
	end

	initial begin : watchdog
		#1_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
